// ===== rtl/assert_macros.svh =====
// Assertion macros used by the top-level RTL file of the colormap unit.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication, checked while reset is released.
`define VCP_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication, checked while reset is released.
`define VCP_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define VCP_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg)
`define VCP_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

// ===== rtl/vcp_pkg.sv =====
// Shared types, widths and Q8.24 coefficients of the viridis colormap unit.
package vcp_pkg;

  // Clamped position is Q16 in [0, 65536].
  localparam int TW     = 17;
  // Horner accumulator, signed Q24; the partial sums stay below 2^33.
  localparam int ACCW   = 34;
  // Product of accumulator and signed position.
  localparam int PRODW  = ACCW + TW + 1;
  localparam int CH     = 3;
  localparam int DEGREE = 6;
  localparam int LVLW   = 16;

  localparam logic [TW-1:0] ONE_Q16 = TW'(65536);

  typedef logic [TW-1:0]          pos_t;
  typedef logic signed [ACCW-1:0] acc_t;
  typedef acc_t                   acc_arr_t [CH];
  typedef logic [LVLW-1:0]        lvl_t;
  typedef lvl_t                   lvl_arr_t [CH];

  // Coefficient row for one power of t, channel order red, green, blue.
  function automatic acc_arr_t coef_row(input logic [2:0] power);
    acc_arr_t row;
    case (power)
      3'd0: row = '{34'sd4659491,   34'sd90720,     34'sd5605265};
      3'd1: row = '{34'sd1763169,   34'sd23565505,  34'sd23229568};
      3'd2: row = '{-34'sd5550940,  34'sd3604544,   34'sd1595432};
      3'd3: row = '{-34'sd77749486, -34'sd97292770, -34'sd324344538};
      3'd4: row = '{34'sd104493030, 34'sd237899805, 34'sd951109646};
      3'd5: row = '{34'sd80134443,  -34'sd230605273, -34'sd1096441945};
      3'd6: row = '{-34'sd91191817, 34'sd77944473,  34'sd441449410};
      default: row = '{default: '0};
    endcase
    return row;
  endfunction

endpackage

// ===== rtl/vcp_horner_stage.sv =====
// One Horner step for all three channels: acc = round(acc * t) + coefficient.
module vcp_horner_stage (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 valid_i,
  output logic                 ready_o,
  input  vcp_pkg::pos_t        t_i,
  input  vcp_pkg::acc_arr_t    acc_i,
  input  vcp_pkg::acc_arr_t    coef_i,
  output logic                 valid_o,
  input  logic                 ready_i,
  output vcp_pkg::pos_t        t_o,
  output vcp_pkg::acc_arr_t    acc_o
);

  logic              valid_r;
  vcp_pkg::pos_t     t_r;
  vcp_pkg::acc_arr_t acc_r;
  vcp_pkg::acc_arr_t acc_nxt;
  logic signed [vcp_pkg::TW:0] t_s;

  // The stage takes a new transfer when empty or when its content moves on.
  assign ready_o = !valid_r || ready_i;
  assign t_s     = $signed({1'b0, t_i});

  // Multiply, round half up to Q24 (floor after adding 2^15), add the coefficient.
  always_comb begin
    logic signed [vcp_pkg::PRODW-1:0] prod;
    logic signed [vcp_pkg::PRODW-1:0] shifted;
    for (int c = 0; c < vcp_pkg::CH; c++) begin
      prod       = acc_i[c] * t_s;
      shifted    = (prod + vcp_pkg::PRODW'(32768)) >>> 16;
      acc_nxt[c] = $signed(shifted[vcp_pkg::ACCW-1:0]) + coef_i[c];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (ready_o) begin
      valid_r <= valid_i;
    end
  end

  always_ff @(posedge clk) begin
    if (valid_i && ready_o) begin
      t_r   <= t_i;
      acc_r <= acc_nxt;
    end
  end

  assign valid_o = valid_r;
  assign t_o     = t_r;
  assign acc_o   = acc_r;

endmodule

// ===== rtl/vcp_out_stage.sv =====
// Output register: clamps each channel to [0,1] and scales it to a 16-bit level.
module vcp_out_stage (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              valid_i,
  output logic              ready_o,
  input  vcp_pkg::acc_arr_t acc_i,
  output logic              valid_o,
  input  logic              ready_i,
  output vcp_pkg::lvl_arr_t lvl_o
);

  localparam int VW = 25;

  logic              valid_r;
  vcp_pkg::lvl_arr_t lvl_r;
  vcp_pkg::lvl_arr_t lvl_nxt;

  assign ready_o = !valid_r || ready_i;

  // level = floor((v * 65535 + 2^23) / 2^24), with v * 65535 = (v << 16) - v.
  always_comb begin
    logic [VW-1:0] v;
    logic [40:0]   wide;
    for (int c = 0; c < vcp_pkg::CH; c++) begin
      if (acc_i[c] < 0) begin
        v = '0;
      end else if (acc_i[c] > vcp_pkg::ACCW'(1 << 24)) begin
        v = VW'(1 << 24);
      end else begin
        v = acc_i[c][VW-1:0];
      end
      wide       = {v, 16'b0} - 41'(v) + 41'(1 << 23);
      lvl_nxt[c] = wide[39:24];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (ready_o) begin
      valid_r <= valid_i;
    end
  end

  always_ff @(posedge clk) begin
    if (valid_i && ready_o) begin
      lvl_r <= lvl_nxt;
    end
  end

  assign valid_o = valid_r;
  assign lvl_o   = lvl_r;

endmodule

// ===== rtl/viridis_colormap_polynomial_unit.sv =====
// Top level of the viridis colormap unit: input clamp, six Horner stages, output scaling.
// The unit maps a signed Q2.16 position t (65536 means 1.0, clamped to 0..1) to red,
// green and blue levels from degree-six viridis polynomials with Q8.24 coefficients,
// each level clamped and scaled so 65535 means 1.0. It takes one transfer every clock
// cycle while the output is not stalled; each result passes the input clamp register,
// one register per Horner multiply-add step (six, each with three 34x18 multipliers),
// and the output clamp and scaling register. Every stage holds its own valid bit and
// refills as soon as its content moves on, so a stall at the output fills the bubbles
// before the input side stops.
`include "assert_macros.svh"

module viridis_colormap_polynomial_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // [17:0] t_value
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata   // [15:0] red_level, [31:16] green_level, [47:32] blue_level
);

  localparam int NST = vcp_pkg::DEGREE;

  logic              v0_r;
  vcp_pkg::pos_t     t0_r;
  vcp_pkg::pos_t     t0_nxt;
  logic signed [17:0] t_in;

  logic [NST:0]      vld_w;
  logic [NST:0]      rdy_w;
  vcp_pkg::pos_t     t_w   [NST+1];
  vcp_pkg::acc_arr_t acc_w [NST+1];
  vcp_pkg::lvl_arr_t lvl_w;

  logic              pipe_stalled;
  logic              in_neg_xfer;

  // Input clamp of the position to [0, 1.0].
  assign t_in      = $signed(in_tdata[17:0]);
  assign in_tready = !v0_r || rdy_w[0];

  always_comb begin
    if (t_in < 0) begin
      t0_nxt = '0;
    end else if (t_in > 18'sd65536) begin
      t0_nxt = vcp_pkg::ONE_Q16;
    end else begin
      t0_nxt = t_in[vcp_pkg::TW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
    end else if (in_tready) begin
      v0_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      t0_r <= t0_nxt;
    end
  end

  assign vld_w[0] = v0_r;
  assign t_w[0]   = t0_r;
  assign acc_w[0] = vcp_pkg::coef_row(3'(vcp_pkg::DEGREE));

  // Horner chain, highest power first.
  for (genvar i = 0; i < NST; i++) begin : g_step
    vcp_horner_stage u_step (
      .clk     (clk),
      .rst_n   (rst_n),
      .valid_i (vld_w[i]),
      .ready_o (rdy_w[i]),
      .t_i     (t_w[i]),
      .acc_i   (acc_w[i]),
      .coef_i  (vcp_pkg::coef_row(3'(vcp_pkg::DEGREE - 1 - i))),
      .valid_o (vld_w[i+1]),
      .ready_i (rdy_w[i+1]),
      .t_o     (t_w[i+1]),
      .acc_o   (acc_w[i+1])
    );
  end

  vcp_out_stage u_out (
    .clk     (clk),
    .rst_n   (rst_n),
    .valid_i (vld_w[NST]),
    .ready_o (rdy_w[NST]),
    .acc_i   (acc_w[NST]),
    .valid_o (out_tvalid),
    .ready_i (out_tready),
    .lvl_o   (lvl_w)
  );

  assign out_tdata = {lvl_w[2], lvl_w[1], lvl_w[0]};

  // Conditions watched by the assertions below.
  assign pipe_stalled = (&vld_w) && out_tvalid && !out_tready;
  assign in_neg_xfer  = in_tvalid && in_tready && in_tdata[17];

  // The input side stops only when every stage is full and the output is stalled.
  `VCP_ASSERT_IMP(a_full_when_blocked, clk, rst_n, !in_tready, pipe_stalled, "bubble at stall")
  // The clamped position never exceeds 1.0.
  `VCP_ASSERT_IMP(a_pos_in_range, clk, rst_n, v0_r, t0_r <= vcp_pkg::ONE_Q16, "t above one")
  // A negative position enters the pipeline as zero.
  `VCP_ASSERT_NXT(a_neg_clamp, clk, rst_n, in_neg_xfer, t0_r == '0, "negative t not clamped")

endmodule
